### sv/crp_pkg.sv
// ----------------------------------------------------------------------------
// crp_pkg
// Shared types, codes and helpers for the cursor position report parser.
// ----------------------------------------------------------------------------
`default_nettype none

package crp_pkg;

    localparam int MAX_REPLY_BYTES_DEF = 32;
    localparam int CNT_W               = 6;
    localparam int TICK_W              = 8;
    localparam int VAL_W               = 16;

    localparam logic [7:0] TIMEOUT_RESET = 8'd40;
    localparam logic [7:0] TICK_MAX      = 8'd255;

    localparam logic [7:0] CH_ESC  = 8'h1b;
    localparam logic [7:0] CH_LBR  = 8'h5b;
    localparam logic [7:0] CH_SEMI = 8'h3b;
    localparam logic [7:0] CH_R    = 8'h52;

    localparam logic [CNT_W-1:0] MIN_REPLY = 6'd6;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_BYTE  = 2'd1,
        OP_TICK  = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        PH_ESC     = 3'd0,
        PH_BRACKET = 3'd1,
        PH_ROW     = 3'd2,
        PH_COL     = 3'd3,
        PH_DONE    = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NONE       = 3'd1,
        ST_SHORT      = 3'd2,
        ST_NO_ESC     = 3'd3,
        ST_NO_BRACKET = 3'd4,
        ST_NO_R       = 3'd5,
        ST_BAD_SEP    = 3'd6,
        ST_BAD_TERM   = 3'd7
    } status_t;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        status_t             status;
        logic [VAL_W-1:0]    row_value;
        logic [VAL_W-1:0]    column_value;
        logic [CNT_W-1:0]    bytes_received;
        logic [TICK_W-1:0]   ticks_elapsed;
    } result_t;

    // acc * 10 + d, saturating at the top of the 16-bit range
    function automatic logic [VAL_W-1:0] add_digit(input logic [VAL_W-1:0] acc,
                                                   input logic [3:0] d);
        logic [VAL_W+3:0] v;
        v = (VAL_W+4)'({acc, 3'b000}) + (VAL_W+4)'({acc, 1'b0}) + (VAL_W+4)'(d);
        return (v > (VAL_W+4)'(16'hffff)) ? {VAL_W{1'b1}} : v[VAL_W-1:0];
    endfunction

endpackage

`default_nettype wire

### sv/crp_input_reg.sv
// ----------------------------------------------------------------------------
// crp_input_reg
// Input register stage: holds one beat until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module crp_input_reg (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire crp_pkg::item_t in_item,
    input  wire logic          advance,
    output logic               item_valid,
    output crp_pkg::item_t     item
);
    import crp_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

### sv/crp_parser.sv
// ----------------------------------------------------------------------------
// crp_parser
// Collection state, on-the-fly report parsing and end-of-window status.
// ----------------------------------------------------------------------------
`default_nettype none

module crp_parser #(
    parameter int MAX_REPLY_BYTES = crp_pkg::MAX_REPLY_BYTES_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_write_en,
    input  wire logic [7:0]     cfg_write_data,
    input  wire logic           fire,
    input  wire crp_pkg::item_t item,
    output logic                has_result,
    output crp_pkg::result_t    result
);
    import crp_pkg::*;

    logic [7:0]        timeout_reg;
    logic              collecting_reg, collecting_next;
    logic [CNT_W-1:0]  byte_count_reg, byte_count_next;
    logic [TICK_W-1:0] tick_count_reg, tick_count_next;
    phase_t            phase_reg, phase_next;
    status_t           error_reg, error_next;
    logic [VAL_W-1:0]  row_reg, row_next;
    logic [VAL_W-1:0]  col_reg, col_next;

    logic              finish;
    logic              ended_on_r;
    logic              is_digit;
    logic [7:0]        limit;
    status_t           st;

    assign is_digit = item.rx_byte inside {[8'h30:8'h39]};
    assign limit    = (timeout_reg == 8'd0) ? 8'd1 : timeout_reg;

    // next state
    always_comb
    begin
        collecting_next = collecting_reg;
        byte_count_next = byte_count_reg;
        tick_count_next = tick_count_reg;
        phase_next      = phase_reg;
        error_next      = error_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        finish          = 1'b0;
        ended_on_r      = 1'b0;
        if (fire)
        begin
            case (item.operation)
                OP_START:
                begin
                    collecting_next = 1'b1;
                    byte_count_next = '0;
                    tick_count_next = '0;
                    phase_next      = PH_ESC;
                    error_next      = ST_OK;
                    row_next        = '0;
                    col_next        = '0;
                end
                OP_BYTE:
                begin
                    if (collecting_reg)
                    begin
                        byte_count_next = byte_count_reg + 1'b1;
                        case (phase_reg)
                            PH_ESC:
                            begin
                                if (item.rx_byte != CH_ESC)
                                begin
                                    error_next = ST_NO_ESC;
                                end
                                phase_next = PH_BRACKET;
                            end
                            PH_BRACKET:
                            begin
                                if (item.rx_byte != CH_LBR && error_reg == ST_OK)
                                begin
                                    error_next = ST_NO_BRACKET;
                                end
                                phase_next = PH_ROW;
                            end
                            PH_ROW:
                            begin
                                if (is_digit)
                                begin
                                    row_next = add_digit(row_reg, item.rx_byte[3:0]);
                                end
                                else if (item.rx_byte == CH_SEMI)
                                begin
                                    phase_next = PH_COL;
                                end
                                else
                                begin
                                    if (error_reg == ST_OK)
                                    begin
                                        error_next = ST_BAD_SEP;
                                    end
                                    phase_next = PH_DONE;
                                end
                            end
                            PH_COL:
                            begin
                                if (is_digit)
                                begin
                                    col_next = add_digit(col_reg, item.rx_byte[3:0]);
                                end
                                else
                                begin
                                    if (item.rx_byte != CH_R && error_reg == ST_OK)
                                    begin
                                        error_next = ST_BAD_TERM;
                                    end
                                    phase_next = PH_DONE;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                        if (item.rx_byte == CH_R)
                        begin
                            finish     = 1'b1;
                            ended_on_r = 1'b1;
                        end
                        else if (byte_count_next >= CNT_W'(MAX_REPLY_BYTES))
                        begin
                            finish = 1'b1;
                        end
                    end
                end
                OP_TICK:
                begin
                    if (collecting_reg)
                    begin
                        if (tick_count_reg < TICK_MAX)
                        begin
                            tick_count_next = tick_count_reg + 1'b1;
                        end
                        if (tick_count_next >= limit)
                        begin
                            finish = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
            if (finish)
            begin
                collecting_next = 1'b0;
            end
        end
    end

    // result
    always_comb
    begin
        if (byte_count_next == '0)
        begin
            st = ST_NONE;
        end
        else if (byte_count_next < MIN_REPLY)
        begin
            st = ST_SHORT;
        end
        else if (error_next == ST_NO_ESC || error_next == ST_NO_BRACKET)
        begin
            st = error_next;
        end
        else if (!ended_on_r)
        begin
            st = ST_NO_R;
        end
        else
        begin
            st = error_next;
        end
        has_result            = finish;
        result.status         = st;
        result.row_value      = (st == ST_OK) ? row_next : '0;
        result.column_value   = (st == ST_OK) ? col_next : '0;
        result.bytes_received = byte_count_next;
        result.ticks_elapsed  = tick_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg    <= TIMEOUT_RESET;
            collecting_reg <= 1'b0;
            byte_count_reg <= '0;
            tick_count_reg <= '0;
            phase_reg      <= PH_ESC;
            error_reg      <= ST_OK;
            row_reg        <= '0;
            col_reg        <= '0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                timeout_reg <= cfg_write_data;
            end
            collecting_reg <= collecting_next;
            byte_count_reg <= byte_count_next;
            tick_count_reg <= tick_count_next;
            phase_reg      <= phase_next;
            error_reg      <= error_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
        end
    end

endmodule

`default_nettype wire

### sv/crp_output_reg.sv
// ----------------------------------------------------------------------------
// crp_output_reg
// Result register: holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module crp_output_reg (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load_valid,
    input  wire crp_pkg::result_t load_data,
    output logic                  advance,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output crp_pkg::result_t      out_data
);
    import crp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // slot is free when empty or being drained this cycle
    assign advance    = !valid_reg || out_ready;
    assign valid_next = advance ? load_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && load_valid)
        begin
            data_reg <= load_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

### sv/cursor_report_parser_top.sv
// A beat waits in the input register and its result, if any, is loaded into
// the result register. Throughput: one input beat per cycle unless stalled;
// the input and result registers are the only stages; the parser updates its
// state in one pass. Backpressure stalls the parser while the result register
// is full and undrained; the input register then takes at most one more beat.
// Reset (rst_n low, asynchronous): idle, counters cleared, timeout_reg = 40.
// ----------------------------------------------------------------------------
// cursor_report_parser_top
// Collects and parses an ESC [ row ; col R cursor position reply.
// ----------------------------------------------------------------------------
`default_nettype none

module cursor_report_parser_top #(
    parameter int MAX_REPLY_BYTES = crp_pkg::MAX_REPLY_BYTES_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_write_en,
    input  wire logic [7:0]                 cfg_write_data,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [1:0]                 operation,
    input  wire logic [7:0]                 rx_byte,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [2:0]                      status,
    output logic [crp_pkg::VAL_W-1:0]       row_value,
    output logic [crp_pkg::VAL_W-1:0]       column_value,
    output logic [crp_pkg::CNT_W-1:0]       bytes_received,
    output logic [crp_pkg::TICK_W-1:0]      ticks_elapsed
);
    import crp_pkg::*;

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    advance;
    logic    has_result;
    result_t result;
    result_t out_data;

    assign in_item.operation = operation;
    assign in_item.rx_byte   = rx_byte;

    crp_input_reg u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    crp_parser #(
        .MAX_REPLY_BYTES (MAX_REPLY_BYTES)
    ) u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .fire           (item_valid && advance),
        .item           (item),
        .has_result     (has_result),
        .result         (result)
    );

    crp_output_reg u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (item_valid && has_result),
        .load_data  (result),
        .advance    (advance),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    assign status         = out_data.status;
    assign row_value      = out_data.row_value;
    assign column_value   = out_data.column_value;
    assign bytes_received = out_data.bytes_received;
    assign ticks_elapsed  = out_data.ticks_elapsed;

endmodule

`default_nettype wire

### sv/crp_checker.sv
// ----------------------------------------------------------------------------
// crp_checker
// Port-level checks on the result channel of the report parser.
// ----------------------------------------------------------------------------
`default_nettype none

module crp_checker #(
    parameter int MAX_REPLY_BYTES = crp_pkg::MAX_REPLY_BYTES_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       out_valid,
    input  wire logic                       out_ready,
    input  wire logic [2:0]                 status,
    input  wire logic [crp_pkg::VAL_W-1:0]  row_value,
    input  wire logic [crp_pkg::VAL_W-1:0]  column_value,
    input  wire logic [crp_pkg::CNT_W-1:0]  bytes_received
);
    import crp_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(bytes_received))
        else $error("result beat dropped or changed while stalled");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> row_value == '0 && column_value == '0)
        else $error("row/column not zero on error status");

    a_ok_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_OK |-> bytes_received >= MIN_REPLY)
        else $error("ok status on a short reply");

    a_max_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> bytes_received <= CNT_W'(MAX_REPLY_BYTES))
        else $error("byte count beyond reply limit");

endmodule

bind cursor_report_parser_top crp_checker #(
    .MAX_REPLY_BYTES (MAX_REPLY_BYTES)
) u_crp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .row_value      (row_value),
    .column_value   (column_value),
    .bytes_received (bytes_received)
);

`default_nettype wire
